// ----- sv/pip_pkg.sv -----
// Shared constants and types for the point-in-polygon test unit.
`default_nettype none

package pip_pkg;

    localparam int MAX_VERTICES = 256;
    localparam int COORD_WIDTH  = 24;

    localparam int INDEX_W = 8;
    localparam int COUNT_W = 9;
    localparam int ADDR_W  = $clog2(MAX_VERTICES);
    localparam int CNT_W   = $clog2(MAX_VERTICES + 1);
    localparam int DIFF_W  = COORD_WIDTH + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int VERT_W  = 2 * COORD_WIDTH;

    localparam int IN_FIELDS_W  = INDEX_W + 4 * COORD_WIDTH;
    localparam int TDATA_IN_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int TDATA_OUT_W  = 8;

    localparam int IDX_LSB = 0;
    localparam int VX_LSB  = IDX_LSB + INDEX_W;
    localparam int VY_LSB  = VX_LSB + COORD_WIDTH;
    localparam int QX_LSB  = VY_LSB + COORD_WIDTH;
    localparam int QY_LSB  = QX_LSB + COORD_WIDTH;

    localparam logic ACTION_LOAD  = 1'b0;
    localparam logic ACTION_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_FINISH
    } state_t;

endpackage

`default_nettype wire

// ----- sv/pip_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module pip_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- sv/point_in_polygon_test_unit.sv -----
// Even-odd ray-crossing point-in-polygon test over a stored vertex list.
//
// Input stream (s_axis_*): tuser selects load (0) or query (1). A load writes
// one vertex into the vertex RAM in the transfer cycle and gives no result.
// A query starts an edge walk: the sequencer reads vertex n-1 and then
// vertices 0..n-1 from the RAM, one read per cycle, and feeds a three-stage
// edge pipeline (differences, two 25x25 products, compare and parity
// toggle). The single RAM read port sets the pace: one edge per cycle.
// Here n is vertex_count clamped to 256; the drain waits while any read or
// crossing edge is still in the pipeline. With n = 0 the walk is skipped
// and the result is outside. No new item is taken during a walk.
// Output stream (m_axis_*): one transfer per query, tdata bit 0 = inside.
// The result sits in an output register; while the receiver stalls the
// block still takes the next item, and a finished walk holds until the
// register frees.
// cfg_we / cfg_wdata write vertex_count; write it only while idle.
// Reset clears vertex_count and control state; the vertex RAM is not
// cleared, and every vertex a query reaches must have been loaded first.
`default_nettype none

module point_in_polygon_test_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [pip_pkg::COUNT_W-1:0]       cfg_wdata,     // vertex_count
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // vertex_index[7:0], vertex_x[31:8], vertex_y[55:32], query_x[79:56],
    // query_y[103:80]
    input  wire logic [pip_pkg::TDATA_IN_W-1:0]    s_axis_tdata,
    input  wire logic                              s_axis_tuser,  // action
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic      [pip_pkg::TDATA_OUT_W-1:0]   m_axis_tdata   // inside_res[0]
);

    import pip_pkg::*;

    state_t state_reg, state_next;

    logic [COUNT_W-1:0] count_reg;
    logic [CNT_W-1:0]   n_eff;
    logic [CNT_W-1:0]   k_reg, k_next;

    logic signed [COORD_WIDTH-1:0] px_reg, py_reg;
    logic signed [COORD_WIDTH-1:0] xj_reg, yj_reg;
    logic signed [COORD_WIDTH-1:0] xi, yi;

    logic rd_v_reg, first_reg;
    logic s1_v_reg, s1_v_next;
    logic s2_v_reg;
    logic signed [DIFF_W-1:0] a_reg, b_reg, dy_reg, ty_reg;
    logic signed [DIFF_W-1:0] a_next, b_next, dy_next, ty_next, dy_raw, ty_raw;
    logic signed [PROD_W-1:0] p1_reg, p2_reg;

    logic parity_reg, parity_next;
    logic out_v_reg, out_d_reg;

    logic s_accept, query_accept, load_accept, load_ok;
    logic rd_issue, out_load;
    logic pipe_busy;

    logic [ADDR_W-1:0] ram_raddr;
    logic [VERT_W-1:0] ram_rdata;
    logic [VERT_W-1:0] ram_wdata;

    assign n_eff = (int'(count_reg) > MAX_VERTICES) ? CNT_W'(MAX_VERTICES)
                                                    : CNT_W'(count_reg);

    assign s_accept     = s_axis_tvalid && s_axis_tready;
    assign query_accept = s_accept && (s_axis_tuser == ACTION_QUERY);
    assign load_ok      = int'(s_axis_tdata[IDX_LSB +: INDEX_W]) < MAX_VERTICES;
    assign load_accept  = s_accept && (s_axis_tuser == ACTION_LOAD) && load_ok;
    assign pipe_busy    = rd_v_reg || s1_v_reg || s2_v_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (query_accept)
                begin
                    state_next = (n_eff == '0) ? ST_FINISH : ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (k_reg == n_eff)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!pipe_busy)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_v_reg || m_axis_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        rd_issue      = 1'b0;
        out_load      = 1'b0;
        unique case (state_reg)
            ST_IDLE:   s_axis_tready = 1'b1;
            ST_WALK:   rd_issue      = 1'b1;
            ST_DRAIN:  rd_issue      = 1'b0;
            ST_FINISH: out_load      = !out_v_reg || m_axis_tready;
            default:   rd_issue      = 1'b0;
        endcase
    end

    assign k_next    = rd_issue ? k_reg + CNT_W'(1) : '0;
    assign ram_raddr = (k_reg == '0) ? ADDR_W'(n_eff - CNT_W'(1))
                                     : ADDR_W'(k_reg - CNT_W'(1));
    assign ram_wdata = {s_axis_tdata[VY_LSB +: COORD_WIDTH],
                        s_axis_tdata[VX_LSB +: COORD_WIDTH]};

    pip_ram #(
        .WIDTH (VERT_W),
        .DEPTH (MAX_VERTICES)
    ) u_vertex_ram (
        .clk   (clk),
        .we    (load_accept),
        .waddr (ADDR_W'(s_axis_tdata[IDX_LSB +: INDEX_W])),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign xi = ram_rdata[COORD_WIDTH-1:0];
    assign yi = ram_rdata[VERT_W-1:COORD_WIDTH];

    // edge differences with the sign of dy folded in
    always_comb
    begin
        dy_raw    = {yj_reg[COORD_WIDTH-1], yj_reg} - {yi[COORD_WIDTH-1], yi};
        ty_raw    = {py_reg[COORD_WIDTH-1], py_reg} - {yi[COORD_WIDTH-1], yi};
        a_next    = {px_reg[COORD_WIDTH-1], px_reg} - {xi[COORD_WIDTH-1], xi};
        b_next    = {xj_reg[COORD_WIDTH-1], xj_reg} - {xi[COORD_WIDTH-1], xi};
        dy_next   = dy_raw[DIFF_W-1] ? -dy_raw : dy_raw;
        ty_next   = dy_raw[DIFF_W-1] ? -ty_raw : ty_raw;
        s1_v_next = rd_v_reg && !first_reg && ((yi > py_reg) != (yj_reg > py_reg));
    end

    always_comb
    begin
        parity_next = parity_reg;
        if (query_accept)
        begin
            parity_next = 1'b0;
        end
        else if (s2_v_reg && (p1_reg < p2_reg))
        begin
            parity_next = !parity_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            k_reg      <= '0;
            rd_v_reg   <= 1'b0;
            s1_v_reg   <= 1'b0;
            s2_v_reg   <= 1'b0;
            parity_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            k_reg      <= k_next;
            rd_v_reg   <= rd_issue;
            s1_v_reg   <= s1_v_next;
            s2_v_reg   <= s1_v_reg;
            parity_reg <= parity_next;
            if (cfg_we)
            begin
                count_reg <= cfg_wdata;
            end
            if (out_load)
            begin
                out_v_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg <= (k_reg == '0);
        if (query_accept)
        begin
            px_reg <= s_axis_tdata[QX_LSB +: COORD_WIDTH];
            py_reg <= s_axis_tdata[QY_LSB +: COORD_WIDTH];
        end
        if (rd_v_reg)
        begin
            xj_reg <= xi;
            yj_reg <= yi;
        end
        a_reg  <= a_next;
        b_reg  <= b_next;
        dy_reg <= dy_next;
        ty_reg <= ty_next;
        p1_reg <= a_reg * dy_reg;
        p2_reg <= b_reg * ty_reg;
        if (out_load)
        begin
            out_d_reg <= parity_reg;
        end
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = {{(TDATA_OUT_W - 1){1'b0}}, out_d_reg};

`ifndef SYNTHESIS
    a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !pipe_busy)
        else $error("edge pipeline active while taking input");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (k_reg <= n_eff))
        else $error("edge walk ran past the vertex count");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside the finish step");
`endif

endmodule

`default_nettype wire

// ----- verif/tb_point_in_polygon_test_unit.sv -----
// Self-checking testbench for the even-odd point-in-polygon test unit.
`timescale 1ns / 1ps

module tb_point_in_polygon_test_unit;
    import pip_pkg::*;

    localparam int  TARGET_ITEMS = 2000;
    localparam int  CYCLE_LIMIT  = 5000000;
    localparam int  SETTLE       = 16;
    localparam int  NUM_DIRECTED = 28;

    localparam logic signed [COORD_WIDTH-1:0] C_MIN = 24'h800000;
    localparam logic signed [COORD_WIDTH-1:0] C_MAX = 24'h7FFFFF;

    typedef enum logic [1:0] {ROW_LOAD, ROW_QUERY, ROW_COUNT} row_kind_t;
    typedef enum logic [1:0] {ANS_PREDICT, ANS_OUTSIDE, ANS_INSIDE} answer_t;

    typedef struct packed {
        row_kind_t                      kind;
        logic [INDEX_W-1:0]             idx;
        logic signed [COORD_WIDTH-1:0]  x;
        logic signed [COORD_WIDTH-1:0]  y;
        logic [COUNT_W-1:0]             count;
        answer_t                        ans;
    } stim_row_t;

    localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
        '{ROW_QUERY, 8'd0,   24'sd0,     24'sd0,     9'd0, ANS_OUTSIDE},
        '{ROW_LOAD,  8'd0,  -24'sd1000, -24'sd1000,  9'd0, ANS_PREDICT},
        '{ROW_LOAD,  8'd1,   24'sd1000, -24'sd1000,  9'd0, ANS_PREDICT},
        '{ROW_LOAD,  8'd2,   24'sd1000,  24'sd1000,  9'd0, ANS_PREDICT},
        '{ROW_LOAD,  8'd3,  -24'sd1000,  24'sd1000,  9'd0, ANS_PREDICT},
        '{ROW_LOAD,  8'd255, C_MAX,      C_MIN,      9'd0, ANS_PREDICT},
        '{ROW_COUNT, 8'd0,   24'sd0,     24'sd0,     9'd4, ANS_PREDICT},
        '{ROW_QUERY, 8'd0,   24'sd0,     24'sd0,     9'd0, ANS_INSIDE},
        '{ROW_QUERY, 8'd0,   24'sd2000,  24'sd0,     9'd0, ANS_OUTSIDE},
        '{ROW_QUERY, 8'd0,  -24'sd1000,  24'sd0,     9'd0, ANS_PREDICT},
        '{ROW_QUERY, 8'd0,   24'sd0,    -24'sd1000,  9'd0, ANS_PREDICT},
        '{ROW_QUERY, 8'd0,   C_MIN,      C_MIN,      9'd0, ANS_OUTSIDE},
        '{ROW_QUERY, 8'd0,   C_MAX,      C_MAX,      9'd0, ANS_OUTSIDE},
        '{ROW_LOAD,  8'd0,   C_MIN,      C_MIN,      9'd0, ANS_PREDICT},
        '{ROW_LOAD,  8'd1,   C_MAX,      C_MIN,      9'd0, ANS_PREDICT},
        '{ROW_LOAD,  8'd2,   C_MAX,      C_MAX,      9'd0, ANS_PREDICT},
        '{ROW_LOAD,  8'd3,   C_MIN,      C_MAX,      9'd0, ANS_PREDICT},
        '{ROW_QUERY, 8'd0,   24'sd0,     24'sd0,     9'd0, ANS_INSIDE},
        '{ROW_QUERY, 8'd0,   C_MIN,      24'sd0,     9'd0, ANS_PREDICT},
        '{ROW_QUERY, 8'd0,   C_MAX,      24'sd8388606, 9'd0, ANS_PREDICT},
        '{ROW_COUNT, 8'd0,   24'sd0,     24'sd0,     9'd3, ANS_PREDICT},
        '{ROW_QUERY, 8'd0,   24'sd8388606, 24'sd0,   9'd0, ANS_PREDICT},
        '{ROW_COUNT, 8'd0,   24'sd0,     24'sd0,     9'd1, ANS_PREDICT},
        '{ROW_QUERY, 8'd0,   24'sd0,     24'sd0,     9'd0, ANS_OUTSIDE},
        '{ROW_COUNT, 8'd0,   24'sd0,     24'sd0,     9'd2, ANS_PREDICT},
        '{ROW_QUERY, 8'd0,   24'sd0,     C_MIN,      9'd0, ANS_PREDICT},
        '{ROW_COUNT, 8'd0,   24'sd0,     24'sd0,     9'd0, ANS_PREDICT},
        '{ROW_QUERY, 8'd0,   24'sd5,     24'sd5,     9'd0, ANS_OUTSIDE}
    };

    logic                    clk           = 1'b0;
    logic                    rst_n         = 1'b0;
    logic                    cfg_we        = 1'b0;
    logic [COUNT_W-1:0]      cfg_wdata     = '0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [TDATA_IN_W-1:0]   s_axis_tdata  = '0;
    logic                    s_axis_tuser  = 1'b0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [TDATA_OUT_W-1:0]  m_axis_tdata;

    logic signed [COORD_WIDTH-1:0] poly_x [MAX_VERTICES];
    logic signed [COORD_WIDTH-1:0] poly_y [MAX_VERTICES];
    logic [COUNT_W-1:0]            poly_count;
    logic                          pending_inside [$];

    int errors     = 0;
    int items_sent = 0;
    int stall_left = 0;
    int cycles     = 0;
    bit quiet      = 1'b0;

    point_in_polygon_test_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic signed [COORD_WIDTH-1:0] pick_coord(input bit tight);
        case ($urandom_range(0, 15))
            0: return C_MIN;
            1: return C_MAX;
            default:
            begin
                if (tight)
                    return COORD_WIDTH'(int'($urandom_range(0, 64)) - 32);
                return COORD_WIDTH'($urandom);
            end
        endcase
    endfunction

    function automatic logic inside_of_polygon(input logic signed [COORD_WIDTH-1:0] px,
                                               input logic signed [COORD_WIDTH-1:0] py);
        int     n;
        int     j;
        longint qx;
        longint qy;
        longint xi;
        longint yi;
        longint xj;
        longint yj;
        longint dy;
        longint ty;
        logic   parity;
        n      = (poly_count > MAX_VERTICES) ? MAX_VERTICES : int'(poly_count);
        qx     = px;
        qy     = py;
        parity = 1'b0;
        for (int i = 0; i < n; i++)
        begin
            j  = (i == 0) ? n - 1 : i - 1;
            xi = poly_x[i];
            yi = poly_y[i];
            xj = poly_x[j];
            yj = poly_y[j];
            if ((yi > qy) != (yj > qy))
            begin
                dy = yj - yi;
                ty = qy - yi;
                if (dy < 0)
                begin
                    dy = -dy;
                    ty = -ty;
                end
                if ((qx - xi) * dy < (xj - xi) * ty)
                    parity = ~parity;
            end
        end
        return parity;
    endfunction

    // Drop valid, wait for every outstanding result, then let the block settle.
    task automatic hold_idle(input int settle);
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_inside.size() != 0);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_count(input logic [COUNT_W-1:0] value);
        hold_idle(SETTLE);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we     <= 1'b0;
        poly_count  = value;
    endtask

    task automatic send_item(input logic act, input logic [INDEX_W-1:0] idx,
                             input logic signed [COORD_WIDTH-1:0] vx,
                             input logic signed [COORD_WIDTH-1:0] vy,
                             input logic signed [COORD_WIDTH-1:0] qx,
                             input logic signed [COORD_WIDTH-1:0] qy,
                             input answer_t ans);
        int gap;
        gap = quiet ? 0 : idle_len();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {qy, qx, vy, vx, idx};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (act == ACTION_LOAD)
        begin
            poly_x[idx] = vx;
            poly_y[idx] = vy;
        end
        else if (ans == ANS_PREDICT)
            pending_inside.push_back(inside_of_polygon(qx, qy));
        else
            pending_inside.push_back(ans == ANS_INSIDE);
        items_sent++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_inside.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got inside=%0b",
                         $time, m_axis_tdata[0]);
                errors++;
            end
            else if (pending_inside[0] !== m_axis_tdata[0])
            begin
                $display("%0t: inside mismatch, expected %0b, got %0b",
                         $time, pending_inside[0], m_axis_tdata[0]);
                errors++;
                void'(pending_inside.pop_front());
            end
            else
                void'(pending_inside.pop_front());
        end
        if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end
        else if (!quiet && $urandom_range(0, 3) == 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= idle_len();
        end
        else
            m_axis_tready <= 1'b1;
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        stim_row_t          row;
        int                 n;
        int                 len;
        int                 phase;
        bit                 tight;
        logic               act;
        logic [INDEX_W-1:0] idx;

        poly_count = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < NUM_DIRECTED; r++)
        begin
            row = DIRECTED_ROWS[r];
            case (row.kind)
                ROW_LOAD:
                    send_item(ACTION_LOAD, row.idx, row.x, row.y,
                              COORD_WIDTH'($urandom), COORD_WIDTH'($urandom), ANS_PREDICT);
                ROW_QUERY:
                    send_item(ACTION_QUERY, INDEX_W'($urandom), COORD_WIDTH'($urandom),
                              COORD_WIDTH'($urandom), row.x, row.y, row.ans);
                default:
                    write_count(row.count);
            endcase
        end

        for (int v = 0; v < MAX_VERTICES; v++)
        begin
            tight = $urandom_range(0, 1);
            send_item(ACTION_LOAD, INDEX_W'(v), pick_coord(tight), pick_coord(tight),
                      COORD_WIDTH'($urandom), COORD_WIDTH'($urandom), ANS_PREDICT);
        end

        phase = 0;
        while (items_sent < TARGET_ITEMS)
        begin
            case (phase)
                0: n = 511;
                1: n = 256;
                2: n = 257;
                3: n = 255;
                default:
                begin
                    case ($urandom_range(0, 19))
                        0:       n = 0;
                        1:       n = $urandom_range(250, 511);
                        2, 3:    n = $urandom_range(1, 2);
                        default: n = $urandom_range(3, 12);
                    endcase
                end
            endcase
            write_count(COUNT_W'(n));
            quiet = ($urandom_range(0, 4) == 0);
            tight = ($urandom_range(0, 2) != 0);
            len   = (n > 12) ? 12 : $urandom_range(20, 60);
            for (int k = 0; k < len; k++)
            begin
                if (k == 5 && phase % 3 == 0)
                    hold_idle(0);
                act = ($urandom_range(0, 9) < 3) ? ACTION_LOAD : ACTION_QUERY;
                if (n > 0 && n < MAX_VERTICES && $urandom_range(0, 3) != 0)
                    idx = INDEX_W'($urandom_range(0, n - 1));
                else
                    idx = INDEX_W'($urandom);
                if (act == ACTION_LOAD)
                    send_item(act, idx, pick_coord(tight), pick_coord(tight),
                              COORD_WIDTH'($urandom), COORD_WIDTH'($urandom), ANS_PREDICT);
                else
                    send_item(act, idx, COORD_WIDTH'($urandom), COORD_WIDTH'($urandom),
                              pick_coord(tight), pick_coord(tight), ANS_PREDICT);
            end
            phase++;
        end

        hold_idle(SETTLE);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
